// File: src/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/qat_pkg.sv
package qat_pkg;

    typedef enum logic [2:0] {
        KIND_BYTE      = 3'd0,
        KIND_UNQ_END   = 3'd1,
        KIND_Q_END     = 3'd2,
        KIND_EQUAL     = 3'd3,
        KIND_EOL       = 3'd4,
        KIND_OVERFLOW  = 3'd5,
        KIND_UNMATCHED = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_QUOTED   = 4'b0010,
        MODE_ESCAPE   = 4'b0100,
        MODE_UNQUOTED = 4'b1000
    } mode_t;

    localparam logic [7:0] CHR_NUL     = 8'h00;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam logic [7:0] CHR_ESC     = 8'h1B;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_DQUOTE  = 8'h22;
    localparam logic [7:0] CHR_STAR    = 8'h2A;
    localparam logic [7:0] CHR_EQUAL   = 8'h3D;
    localparam logic [7:0] CHR_UPPER_N = 8'h4E;
    localparam logic [7:0] CHR_LOWER_N = 8'h6E;
    localparam logic [7:0] CHR_UPPER_E = 8'h45;
    localparam logic [7:0] CHR_LOWER_E = 8'h65;

    localparam int unsigned CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 16'd256;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // one queue entry: the results caused by one item
    typedef struct packed {
        logic       two;
        kind_t      kind0;
        kind_t      kind1;
        logic [7:0] chr;
    } entry_t;

endpackage

// File: src/qat_if.sv
interface qat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       ignore_equal;

    modport source (output valid, output in_byte, output end_of_input,
                    output ignore_equal, input ready);
    modport sink (input valid, input in_byte, input end_of_input,
                  input ignore_equal, output ready);
endinterface

interface qat_out_if;
    logic            valid;
    logic            ready;
    qat_pkg::kind_t  kind;
    logic [7:0]      out_byte;
    logic            last;

    modport source (output valid, output kind, output out_byte, output last,
                    input ready);
    modport sink (input valid, input kind, input out_byte, input last,
                  output ready);
endinterface

// File: src/qat_front.sv
module qat_front #(
    parameter int unsigned LEN_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    qat_in_if.sink                          in_ch,
    input  logic                            cfg_wr_en,
    input  logic [qat_pkg::CFG_WIDTH-1:0]   cfg_wr_data,
    input  logic                            push_ready,
    output logic                            push_valid,
    output qat_pkg::entry_t                 push_entry
);
    import qat_pkg::*;

    typedef struct packed {
        logic                 emit;
        kind_t                kind;
        logic [7:0]           chr;
        mode_t                mode;
        logic                 load;
        logic [LEN_WIDTH-1:0] reads;
        logic                 set_plain;
    } idle_res_t;

    localparam logic [32:0] LEN_MAX = (33'd1 << LEN_WIDTH) - 33'd1;

    logic [CFG_WIDTH-1:0] max_len_reg;
    mode_t                mode_reg, mode_next;
    logic [LEN_WIDTH-1:0] reads_reg, reads_next;
    logic                 plain_reg, plain_next;
    logic [LEN_WIDTH-1:0] lim;
    logic                 accept;
    logic                 has_result;
    logic                 is_term;
    logic [7:0]           esc_chr;
    idle_res_t            idl;
    entry_t               ent;

    function automatic idle_res_t idle_step(input logic [7:0] c, input logic eof,
                                            input logic ign,
                                            input logic [LEN_WIDTH-1:0] l);
        idle_res_t r;
        r.emit      = 1'b0;
        r.kind      = KIND_EOL;
        r.chr       = c;
        r.mode      = MODE_IDLE;
        r.load      = 1'b0;
        r.reads     = l;
        r.set_plain = 1'b0;
        if (!eof && (c == CHR_SPACE || c == CHR_TAB || c == CHR_LF)) begin
            r.emit = 1'b0;
        end else if (eof || c == CHR_NUL) begin
            r.emit = 1'b1;
            r.kind = KIND_EOL;
        end else if (!ign && c == CHR_EQUAL) begin
            r.emit = 1'b1;
            r.kind = KIND_EQUAL;
        end else begin
            r.set_plain = 1'b1;
            if (c == CHR_DQUOTE) begin
                r.load  = 1'b1;
                r.reads = l;
                r.mode  = MODE_QUOTED;
            end else if (l == '0) begin
                r.emit = 1'b1;
                r.kind = KIND_OVERFLOW;
            end else begin
                r.load  = 1'b1;
                r.reads = l - LEN_WIDTH'(1);
                r.mode  = MODE_UNQUOTED;
                r.emit  = 1'b1;
                r.kind  = KIND_BYTE;
            end
        end
        return r;
    endfunction

    // limit saturated to the counter range
    assign lim = (33'(max_len_reg) > LEN_MAX) ? LEN_MAX[LEN_WIDTH-1:0]
                                              : LEN_WIDTH'(max_len_reg);

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;
    assign push_valid  = accept && has_result;
    assign push_entry  = ent;

    assign is_term = in_ch.end_of_input || in_ch.in_byte == CHR_NUL
                     || in_ch.in_byte == CHR_SPACE || in_ch.in_byte == CHR_TAB
                     || in_ch.in_byte == CHR_LF
                     || (!plain_reg && in_ch.in_byte == CHR_EQUAL);

    always_comb
    begin
        if (in_ch.in_byte == CHR_LOWER_N || in_ch.in_byte == CHR_UPPER_N) begin
            esc_chr = CHR_LF;
        end else if (in_ch.in_byte == CHR_LOWER_E || in_ch.in_byte == CHR_UPPER_E) begin
            esc_chr = CHR_ESC;
        end else begin
            esc_chr = in_ch.in_byte;
        end
    end

    always_comb
    begin
        idl        = idle_step(in_ch.in_byte, in_ch.end_of_input, in_ch.ignore_equal, lim);
        mode_next  = mode_reg;
        reads_next = reads_reg;
        plain_next = plain_reg;
        has_result = 1'b0;
        ent.two    = 1'b0;
        ent.kind0  = KIND_BYTE;
        ent.kind1  = KIND_BYTE;
        ent.chr    = in_ch.in_byte;
        case (mode_reg)
            MODE_IDLE:
            begin
                has_result = idl.emit;
                ent.kind0  = idl.kind;
                mode_next  = idl.mode;
                if (idl.load) begin
                    reads_next = idl.reads;
                end
                if (idl.set_plain) begin
                    plain_next = in_ch.ignore_equal;
                end
            end
            MODE_QUOTED:
            begin
                has_result = 1'b1;
                if (reads_reg == '0) begin
                    ent.kind0 = KIND_OVERFLOW;
                    mode_next = MODE_IDLE;
                end else begin
                    reads_next = reads_reg - LEN_WIDTH'(1);
                    if (in_ch.end_of_input || in_ch.in_byte == CHR_NUL
                        || in_ch.in_byte == CHR_LF) begin
                        ent.kind0 = KIND_UNMATCHED;
                        mode_next = MODE_IDLE;
                    end else if (in_ch.in_byte == CHR_STAR) begin
                        has_result = 1'b0;
                        mode_next  = MODE_ESCAPE;
                    end else if (in_ch.in_byte == CHR_DQUOTE) begin
                        ent.kind0 = KIND_Q_END;
                        mode_next = MODE_IDLE;
                    end else begin
                        ent.kind0 = KIND_BYTE;
                    end
                end
            end
            MODE_ESCAPE:
            begin
                has_result = 1'b1;
                if (in_ch.end_of_input || in_ch.in_byte == CHR_NUL
                    || in_ch.in_byte == CHR_LF) begin
                    ent.kind0 = KIND_UNMATCHED;
                    mode_next = MODE_IDLE;
                end else begin
                    ent.kind0 = KIND_BYTE;
                    ent.chr   = esc_chr;
                    mode_next = MODE_QUOTED;
                end
            end
            MODE_UNQUOTED:
            begin
                has_result = 1'b1;
                if (reads_reg == '0) begin
                    ent.kind0 = KIND_OVERFLOW;
                    mode_next = MODE_IDLE;
                end else begin
                    reads_next = reads_reg - LEN_WIDTH'(1);
                    if (is_term) begin
                        // terminator goes through idle once more
                        ent.kind0 = plain_reg ? KIND_Q_END : KIND_UNQ_END;
                        ent.two   = idl.emit;
                        ent.kind1 = idl.kind;
                        mode_next = idl.mode;
                        if (idl.load) begin
                            reads_next = idl.reads;
                        end
                        if (idl.set_plain) begin
                            plain_next = in_ch.ignore_equal;
                        end
                    end else begin
                        ent.kind0 = KIND_BYTE;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg <= CFG_RESET;
            mode_reg    <= MODE_IDLE;
            reads_reg   <= '0;
            plain_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (accept) begin
                mode_reg  <= mode_next;
                reads_reg <= reads_next;
                plain_reg <= plain_next;
            end
        end
    end

endmodule

// File: src/qat_queue.sv
module qat_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  qat_pkg::entry_t  push_entry,
    output logic             push_ready,
    input  logic             pop,
    output logic             head_valid,
    output qat_pkg::entry_t  head_entry
);
    import qat_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: src/qat_back.sv
module qat_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  qat_pkg::entry_t  head_entry,
    output logic             pop,
    qat_out_if.source        out_ch
);
    import qat_pkg::*;

    logic       valid_reg;
    kind_t      kind_reg, kind_next;
    logic [7:0] chr_reg;
    logic       last_reg, last_next;
    logic       sel_reg;
    logic       load;

    assign load = head_valid && (!valid_reg || out_ch.ready);

    // first of a pair goes out with last low, then the second pops the entry
    always_comb
    begin
        if (head_entry.two && !sel_reg) begin
            kind_next = head_entry.kind0;
            last_next = 1'b0;
        end else begin
            kind_next = sel_reg ? head_entry.kind1 : head_entry.kind0;
            last_next = 1'b1;
        end
    end

    assign pop = load && last_next;

    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg <= kind_next;
            chr_reg  <= (kind_next == KIND_BYTE) ? head_entry.chr : 8'h00;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                sel_reg   <= !last_next;
            end else if (out_ch.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid    = valid_reg;
    assign out_ch.kind     = kind_reg;
    assign out_ch.out_byte = chr_reg;
    assign out_ch.last     = last_reg;

endmodule

// File: src/quoted_argument_tokenizer.sv
// quoted argument tokenizer
// in_ch carries one character item per handshake (in_byte, end_of_input,
// ignore_equal); out_ch carries result items (kind, out_byte, last), zero to
// two per input item, last high on the final one of each input item.
// cfg_wr_en with cfg_wr_data sets the per-token read limit (256 after reset);
// write it only while the block is idle.
// a front stage classifies each character in the cycle it is accepted and
// pushes its results into a four-entry queue; a back stage drains the queue
// into the output register, one result per cycle while out_ch is ready.
// a result passes through a queue entry and then the output register on
// its way to out_ch. throughput: one input item per cycle while out_ch is
// ready and results keep to one per item; an item with two results sends
// them out one after the other. when out_ch stalls, input keeps being taken
// until the queue fills, then in_ch.ready drops.
// reset empties the queue and output register, returns the scanner to idle
// and loads the default limit.
module quoted_argument_tokenizer #(
    parameter int unsigned LEN_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    qat_in_if.sink                          in_ch,
    qat_out_if.source                       out_ch,
    input  logic                            cfg_wr_en,
    input  logic [qat_pkg::CFG_WIDTH-1:0]   cfg_wr_data
);
    import qat_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    qat_front #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    qat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    qat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

// File: src/qat_checker.sv
`include "assert_macros.svh"

module qat_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] kind,
    input  logic [7:0] out_byte,
    input  logic       last
);
    import qat_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `ASSERT_SAME(a_byte_zero, clk, rst_n, out_valid && kind != KIND_BYTE, out_byte == 8'h00, "out_byte set on a non-byte result")
    `ASSERT_SAME(a_first_is_end, clk, rst_n, out_valid && !last, kind == KIND_UNQ_END || kind == KIND_Q_END, "first of two results is not a token end")
    `ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !last, out_valid, "second result of an item missing")

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.kind),
    .out_byte  (out_ch.out_byte),
    .last      (out_ch.last)
);
